// File: sv/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg : shared definitions of the text cell buffer editor
// character codes, key codes, mode codes, sequencer states and caret ops
// ----------------------------------------------------------------------------
package tcb_pkg;

  // default sizing
  localparam int unsigned DEF_MAX_COLS = 128;
  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_TAB_STOP = 8;

  // register reset values
  localparam logic [7:0] RST_COLUMNS = 8'd80;
  localparam logic [6:0] RST_ROWS    = 7'd25;

  // register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // item modes
  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_KEY  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // control characters
  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_ESC   = 8'h1B;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // navigation keys
  localparam logic [7:0] KEY_HOME   = 8'd0;
  localparam logic [7:0] KEY_END    = 8'd1;
  localparam logic [7:0] KEY_TOP    = 8'd2;
  localparam logic [7:0] KEY_BOTTOM = 8'd3;
  localparam logic [7:0] KEY_LEFT   = 8'd4;
  localparam logic [7:0] KEY_RIGHT  = 8'd5;
  localparam logic [7:0] KEY_UP     = 8'd6;
  localparam logic [7:0] KEY_DOWN   = 8'd7;
  localparam logic [7:0] KEY_DEL    = 8'd8;

  // caret unit operations
  typedef enum logic [3:0] {
    OP_HOLD,
    OP_CLAMP,
    OP_ADVANCE,
    OP_NEXT_ROW,
    OP_CR,
    OP_HOME_ALL,
    OP_LEFT,
    OP_RIGHT,
    OP_UP,
    OP_DOWN,
    OP_LINE_START,
    OP_LINE_END,
    OP_TOP,
    OP_BOTTOM
  } alu_op_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_FILL,
    ST_PUT,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DEL_END,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } tcb_state_e;

  // one bit per column value 0..255, set where the column is a tab stop
  function automatic logic [255:0] tab_stop_map(int unsigned tab);
    logic [255:0] m;
    m = '0;
    for (int unsigned k = 0; k < 256; k += tab) begin
      m[8'(k)] = 1'b1;
    end
    return m;
  endfunction

endpackage

// File: sv/tcb_ram.sv
// ----------------------------------------------------------------------------
// tcb_ram : generic single-port ram
// one address per cycle, write or read, read data registered
// ----------------------------------------------------------------------------
module tcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tcb_caret_alu.sv
// ----------------------------------------------------------------------------
// tcb_caret_alu : shared caret arithmetic
// increment, decrement, wrap and clamp of the caret against the area in use
// ----------------------------------------------------------------------------
module tcb_caret_alu #(
  parameter int unsigned CW = 7,
  parameter int unsigned RW = 6
) (
  input  tcb_pkg::alu_op_e op_i,
  input  logic [CW-1:0]    x_i,
  input  logic [RW-1:0]    y_i,
  input  logic [CW-1:0]    c_last_i,
  input  logic [RW-1:0]    r_last_i,
  output logic [CW-1:0]    x_o,
  output logic [RW-1:0]    y_o
);

  logic [RW-1:0] next_row;

  // row below, wrapping to the top
  assign next_row = (y_i >= r_last_i) ? '0 : y_i + RW'(1);

  always_comb begin
    x_o = x_i;
    y_o = y_i;
    case (op_i)
      tcb_pkg::OP_CLAMP: begin
        if (x_i > c_last_i) x_o = c_last_i;
        if (y_i > r_last_i) y_o = r_last_i;
      end
      tcb_pkg::OP_ADVANCE: begin
        if (x_i >= c_last_i) begin
          x_o = '0;
          y_o = next_row;
        end else begin
          x_o = x_i + CW'(1);
        end
      end
      tcb_pkg::OP_NEXT_ROW: y_o = next_row;
      tcb_pkg::OP_CR: begin
        x_o = '0;
        y_o = next_row;
      end
      tcb_pkg::OP_HOME_ALL: begin
        x_o = '0;
        y_o = '0;
      end
      tcb_pkg::OP_LEFT: begin
        if (x_i != '0) x_o = x_i - CW'(1);
      end
      tcb_pkg::OP_RIGHT: begin
        if (x_i < c_last_i) x_o = x_i + CW'(1);
      end
      tcb_pkg::OP_UP: begin
        if (y_i != '0) y_o = y_i - RW'(1);
      end
      tcb_pkg::OP_DOWN: begin
        if (y_i < r_last_i) y_o = y_i + RW'(1);
      end
      tcb_pkg::OP_LINE_START: x_o = '0;
      tcb_pkg::OP_LINE_END:   x_o = c_last_i;
      tcb_pkg::OP_TOP:        y_o = '0;
      tcb_pkg::OP_BOTTOM:     y_o = r_last_i;
      default: begin
        x_o = x_i;
        y_o = y_i;
      end
    endcase
  end

endmodule

// File: sv/tcb_ctrl.sv
// ----------------------------------------------------------------------------
// tcb_ctrl : item sequencer of the text cell buffer editor
// walks one item through caret ops, row fills, row shifts and cell reads
// ----------------------------------------------------------------------------
module tcb_ctrl #(
  parameter int unsigned MAX_COLS = tcb_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tcb_pkg::DEF_MAX_ROWS,
  parameter int unsigned TAB_STOP = tcb_pkg::DEF_TAB_STOP,
  localparam int unsigned CW      = $clog2(MAX_COLS),
  localparam int unsigned RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned AW      = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // item in
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    code_i,
  input  logic [3:0]    rep_i,
  input  logic [6:0]    rcol_i,
  input  logic [5:0]    rrow_i,
  // area in use
  input  logic [CW-1:0] c_last_i,
  input  logic [RW-1:0] r_last_i,
  // result out
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [CW-1:0] res_x_o,
  output logic [RW-1:0] res_y_o,
  output logic [7:0]    res_cell_o,
  // cell store
  output logic          ram_we_o,
  output logic [AW-1:0] ram_addr_o,
  output logic [7:0]    ram_wdata_o,
  input  logic [7:0]    ram_rdata_i
);

  localparam logic [255:0]  STOP_MAP = tcb_pkg::tab_stop_map(TAB_STOP);
  localparam logic [CW-1:0] COL_END  = CW'(MAX_COLS - 1);

  tcb_pkg::tcb_state_e state_q, state_d;
  tcb_pkg::alu_op_e    alu_op;

  logic [1:0]          mode_q;
  logic [7:0]          code_q;
  logic [3:0]          rep_q, rep_d;
  logic [CW-1:0]       rcol_q;
  logic [RW-1:0]       rrow_q;
  logic [CW-1:0]       x_q, x_d, x_n;
  logic [RW-1:0]       y_q, y_d, y_n;
  logic [CW-1:0]       ptr_q, ptr_d, ptr_inc;
  logic                tab_q, tab_d;
  logic [7:0]          cell_q, cell_d;
  logic [MAX_ROWS-1:0] rowv_q, rowv_d;

  logic [8:0]          rc_ext;
  logic [7:0]          rr_ext;
  logic                rd_in_range;
  logic                accept;
  logic                row_ok;
  logic [RW-1:0]       row_sel;
  logic [CW-1:0]       col_sel;

  assign rc_ext      = 9'(rcol_i);
  assign rr_ext      = 8'(rrow_i);
  assign rd_in_range = (rc_ext < 9'(MAX_COLS)) && (rr_ext < 8'(MAX_ROWS));
  assign accept      = in_valid_i && in_ready_o;
  assign row_ok      = rowv_q[y_q];
  assign ptr_inc     = ptr_q + CW'(1);

  tcb_caret_alu #(
    .CW (CW),
    .RW (RW)
  ) u_alu (
    .op_i     (alu_op),
    .x_i      (x_q),
    .y_i      (y_q),
    .c_last_i (c_last_i),
    .r_last_i (r_last_i),
    .x_o      (x_n),
    .y_o      (y_n)
  );

  // row-major cell address
  assign ram_addr_o = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcb_pkg::ST_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      rowv_q  <= '0;
      tab_q   <= 1'b0;
      rep_q   <= '0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      y_q     <= y_d;
      rowv_q  <= rowv_d;
      tab_q   <= tab_d;
      rep_q   <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      code_q <= code_i;
      rcol_q <= rc_ext[CW-1:0];
      rrow_q <= rr_ext[RW-1:0];
    end
    ptr_q  <= ptr_d;
    cell_q <= cell_d;
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    rep_d       = rep_q;
    ptr_d       = ptr_q;
    tab_d       = tab_q;
    cell_d      = cell_q;
    rowv_d      = rowv_q;
    alu_op      = tcb_pkg::OP_HOLD;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_wdata_o = tcb_pkg::CHR_SPACE;
    row_sel     = y_q;
    col_sel     = x_q;

    case (state_q)
      tcb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        // keeps the caret inside the area after a register write
        alu_op = tcb_pkg::OP_CLAMP;
        x_d    = x_n;
        y_d    = y_n;
        if (in_valid_i) begin
          rep_d  = rep_i;
          tab_d  = 1'b0;
          cell_d = '0;
          case (mode_i)
            tcb_pkg::MODE_CHAR: state_d = tcb_pkg::ST_APPLY;
            tcb_pkg::MODE_KEY:  state_d = tcb_pkg::ST_APPLY;
            tcb_pkg::MODE_READ: begin
              state_d = rd_in_range ? tcb_pkg::ST_READ : tcb_pkg::ST_DONE;
            end
            default: state_d = tcb_pkg::ST_DONE;
          endcase
        end
      end

      tcb_pkg::ST_APPLY: begin
        if (mode_q == tcb_pkg::MODE_KEY) begin
          state_d = tcb_pkg::ST_DONE;
          case (code_q)
            tcb_pkg::KEY_HOME:   alu_op = tcb_pkg::OP_LINE_START;
            tcb_pkg::KEY_END:    alu_op = tcb_pkg::OP_LINE_END;
            tcb_pkg::KEY_TOP:    alu_op = tcb_pkg::OP_TOP;
            tcb_pkg::KEY_BOTTOM: alu_op = tcb_pkg::OP_BOTTOM;
            tcb_pkg::KEY_LEFT:   alu_op = tcb_pkg::OP_LEFT;
            tcb_pkg::KEY_RIGHT:  alu_op = tcb_pkg::OP_RIGHT;
            tcb_pkg::KEY_UP:     alu_op = tcb_pkg::OP_UP;
            tcb_pkg::KEY_DOWN:   alu_op = tcb_pkg::OP_DOWN;
            tcb_pkg::KEY_DEL: begin
              // a blank row stays blank under a delete
              if (row_ok) begin
                ptr_d   = x_q;
                state_d = tcb_pkg::ST_DEL_RD;
              end
            end
            default: alu_op = tcb_pkg::OP_HOLD;
          endcase
          x_d = x_n;
          y_d = y_n;
        end else if (rep_q == '0) begin
          state_d = tcb_pkg::ST_DONE;
        end else begin
          case (code_q)
            tcb_pkg::CHR_BS: begin
              rep_d = rep_q - 4'd1;
              if (x_q != '0) begin
                alu_op = tcb_pkg::OP_LEFT;
                x_d    = x_n;
                if (row_ok) begin
                  rep_d   = rep_q;
                  ptr_d   = x_n;
                  state_d = tcb_pkg::ST_DEL_RD;
                end
              end
            end
            tcb_pkg::CHR_TAB: begin
              tab_d   = 1'b1;
              ptr_d   = '0;
              state_d = row_ok ? tcb_pkg::ST_PUT : tcb_pkg::ST_FILL;
            end
            tcb_pkg::CHR_LF: begin
              alu_op = tcb_pkg::OP_NEXT_ROW;
              y_d    = y_n;
              rep_d  = rep_q - 4'd1;
            end
            tcb_pkg::CHR_CR: begin
              alu_op = tcb_pkg::OP_CR;
              x_d    = x_n;
              y_d    = y_n;
              rep_d  = rep_q - 4'd1;
            end
            tcb_pkg::CHR_ESC: begin
              // every row back to blank at once
              rowv_d = '0;
              alu_op = tcb_pkg::OP_HOME_ALL;
              x_d    = x_n;
              y_d    = y_n;
              rep_d  = rep_q - 4'd1;
            end
            default: begin
              ptr_d   = '0;
              state_d = row_ok ? tcb_pkg::ST_PUT : tcb_pkg::ST_FILL;
            end
          endcase
        end
      end

      tcb_pkg::ST_FILL: begin
        // blank the whole row before its first real write
        col_sel  = ptr_q;
        ram_we_o = 1'b1;
        ptr_d    = ptr_inc;
        if (ptr_q == COL_END) begin
          rowv_d[y_q] = 1'b1;
          state_d     = tcb_pkg::ST_PUT;
        end
      end

      tcb_pkg::ST_PUT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = tab_q ? tcb_pkg::CHR_SPACE : code_q;
        alu_op      = tcb_pkg::OP_ADVANCE;
        x_d         = x_n;
        y_d         = y_n;
        if (tab_q && !STOP_MAP[8'(x_n)]) begin
          ptr_d   = '0;
          state_d = rowv_q[y_n] ? tcb_pkg::ST_PUT : tcb_pkg::ST_FILL;
        end else begin
          tab_d   = 1'b0;
          rep_d   = rep_q - 4'd1;
          state_d = tcb_pkg::ST_APPLY;
        end
      end

      tcb_pkg::ST_DEL_RD: begin
        if (ptr_q < c_last_i) begin
          col_sel = ptr_inc;
          state_d = tcb_pkg::ST_DEL_WR;
        end else begin
          state_d = tcb_pkg::ST_DEL_END;
        end
      end

      tcb_pkg::ST_DEL_WR: begin
        col_sel     = ptr_q;
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        ptr_d       = ptr_inc;
        state_d     = tcb_pkg::ST_DEL_RD;
      end

      tcb_pkg::ST_DEL_END: begin
        col_sel  = c_last_i;
        ram_we_o = 1'b1;
        if (mode_q == tcb_pkg::MODE_KEY) begin
          state_d = tcb_pkg::ST_DONE;
        end else begin
          rep_d   = rep_q - 4'd1;
          state_d = tcb_pkg::ST_APPLY;
        end
      end

      tcb_pkg::ST_READ: begin
        row_sel = rrow_q;
        col_sel = rcol_q;
        state_d = tcb_pkg::ST_READ_WAIT;
      end

      tcb_pkg::ST_READ_WAIT: begin
        cell_d  = rowv_q[rrow_q] ? ram_rdata_i : tcb_pkg::CHR_SPACE;
        state_d = tcb_pkg::ST_DONE;
      end

      tcb_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = tcb_pkg::ST_IDLE;
        end
      end

      default: state_d = tcb_pkg::ST_IDLE;
    endcase
  end

  assign res_x_o    = x_q;
  assign res_y_o    = y_q;
  assign res_cell_o = cell_q;

endmodule

// File: sv/text_cell_buffer_editor.sv
// ----------------------------------------------------------------------------
// text_cell_buffer_editor : character-cell text buffer with a caret
// applies character, navigation and read items to a row-major cell store
// ----------------------------------------------------------------------------
//
// channel     dir  handshake                       payload
// s_axis      in   s_axis_tvalid / s_axis_tready   tdata: code, repeat_req,
//                                                  read_col, read_row
//                                                  tuser: mode
// m_axis      out  m_axis_tvalid / m_axis_tready   tdata: caret_col, caret_row,
//                                                  cell_char
// cfg         in   cfg_we_i                        cfg_idx_i, cfg_data_i
//
// one item at a time; s_axis_tready is high only while the sequencer is idle
// a read fetches one cell; a read outside the store or an unused mode goes
//   straight to the result; a key moves the caret, and a delete on a written
//   row shifts the rest of the row left and blanks its last column; each repeat
//   of a character: lf, cr, esc move the caret, a backspace off column 0 moves
//   left and on a written row also shifts, a tab or a stored code puts cells,
//   and a row is blank-filled when written for the first time since reset or
//   escape; the single-port cell store sets the pace of row fills and shifts
// reset: rows are marked blank through one valid bit each, so no clearing pass;
//   escape clears the same bits at once
// a finished result waits in the output register; the next item is taken
//   while it waits, and the sequencer holds at its end only while that
//   register is still full
//
module text_cell_buffer_editor #(
  parameter int unsigned MAX_COLS = tcb_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tcb_pkg::DEF_MAX_ROWS,
  parameter int unsigned TAB_STOP = tcb_pkg::DEF_TAB_STOP
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // items in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // code[7:0], repeat_req[11:8], read_col[18:12],
                                     // read_row[24:19], zero[31:25]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  // results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // caret_col[6:0], caret_row[12:7],
                                     // cell_char[20:13], zero[23:21]
  // register writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration registers, held raw as written (rows keeps the low seven bits)
  logic [7:0]    cols_q;
  logic [6:0]    rows_q;

  // last column and last row of the area in use
  logic [8:0]    cols_ext, c_last_ext;
  logic [7:0]    rows_ext, r_last_ext;
  logic [CW-1:0] c_last;
  logic [RW-1:0] r_last;

  // sequencer result
  logic          res_valid, res_ready;
  logic [CW-1:0] res_x;
  logic [RW-1:0] res_y;
  logic [7:0]    res_cell;

  // cell store port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  // output register
  logic          out_valid_q;
  logic [23:0]   out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tcb_pkg::RST_COLUMNS;
      rows_q <= tcb_pkg::RST_ROWS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcb_pkg::REG_COLUMNS: cols_q <= cfg_data_i;
        tcb_pkg::REG_ROWS:    rows_q <= cfg_data_i[6:0];
        default: begin
          cols_q <= cols_q;
          rows_q <= rows_q;
        end
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  assign cols_ext = 9'(cols_q);
  assign rows_ext = 8'(rows_q);

  always_comb begin
    if (cols_ext == '0) begin
      c_last_ext = '0;
    end else if (cols_ext > 9'(MAX_COLS)) begin
      c_last_ext = 9'(MAX_COLS - 1);
    end else begin
      c_last_ext = cols_ext - 9'd1;
    end
    if (rows_ext == '0) begin
      r_last_ext = '0;
    end else if (rows_ext > 8'(MAX_ROWS)) begin
      r_last_ext = 8'(MAX_ROWS - 1);
    end else begin
      r_last_ext = rows_ext - 8'd1;
    end
  end

  assign c_last = c_last_ext[CW-1:0];
  assign r_last = r_last_ext[RW-1:0];

  tcb_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser[1:0]),
    .code_i      (s_axis_tdata[7:0]),
    .rep_i       (s_axis_tdata[11:8]),
    .rcol_i      (s_axis_tdata[18:12]),
    .rrow_i      (s_axis_tdata[24:19]),
    .c_last_i    (c_last),
    .r_last_i    (r_last),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_x_o     (res_x),
    .res_y_o     (res_y),
    .res_cell_o  (res_cell),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  tcb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // output register: free, or emptied in this same cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {3'b000, res_cell, 6'(res_y), 7'(res_x)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
